// ===== src/sfr_pkg.sv =====
// ----------------------------------------------------------------------------
// sfr_pkg
// Types and constants shared by the serial frame receiver modules.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam logic [7:0] HEAD_BYTE = 8'h02;
  localparam logic [7:0] TAIL_BYTE = 8'h03;

  // Header and length field take three bytes before the payload.
  localparam logic [8:0] PAYLOAD_OFS = 9'd3;

  typedef enum logic {
    OP_RX   = 1'b0,
    OP_READ = 1'b1
  } sfr_op_t;

  typedef enum logic [2:0] {
    ST_NONE     = 3'd0,
    ST_OK       = 3'd1,
    ST_MISMATCH = 3'd2,
    ST_NO_HEAD  = 3'd3,
    ST_OVERFLOW = 3'd4
  } sfr_status_t;

  typedef struct packed {
    logic       operation;
    logic [7:0] rx_byte;
    logic [7:0] read_index;
  } sfr_in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] payload_length;
    logic [7:0] read_data;
  } sfr_out_t;

  // Command from the front part to the back part (address travels apart).
  typedef struct packed {
    logic        wr;      // store data at address
    logic        rd_ok;   // read store at address, else read data is zero
    sfr_status_t status;
    logic [7:0]  length;
    logic [7:0]  data;
  } sfr_cmd_t;

endpackage

// ===== src/sfr_front.sv =====
// ----------------------------------------------------------------------------
// sfr_front
// Classifies each request, tracks frame state and length, emits store commands.
// ----------------------------------------------------------------------------
module sfr_front #(
  parameter int BUF_DEPTH = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  input  logic                         cfg_data,
  input  logic                         accept,
  input  sfr_pkg::sfr_in_t             in_data,
  output sfr_pkg::sfr_cmd_t            cmd,
  output logic [$clog2(BUF_DEPTH)-1:0] cmd_addr
);
  import sfr_pkg::*;

  localparam int AW = $clog2(BUF_DEPTH);
  localparam int CW = $clog2(BUF_DEPTH + 1);
  localparam int DW = (CW > 16) ? CW : 16;

  logic          crc_r;
  logic          in_frame_r, in_frame_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic [7:0]    last_len_r, last_len_nxt;
  logic [7:0]    len_hi_r, len_hi_nxt;
  logic [7:0]    len_lo_r, len_lo_nxt;
  logic [8:0]    rd_pos;
  logic [15:0]   field;
  logic [DW-1:0] ovh, cnt_ext;
  logic          match;

  assign cnt_inc = cnt_r + CW'(1);
  assign rd_pos  = 9'(in_data.read_index) + PAYLOAD_OFS;
  assign field   = {len_hi_r, len_lo_r};
  assign ovh     = crc_r ? DW'(8) : DW'(4);
  assign cnt_ext = DW'(cnt_inc);
  assign match   = (cnt_ext >= ovh) && ((cnt_ext - ovh) == DW'(field));

  always_comb begin
    cmd          = '0;
    cmd.status   = ST_NONE;
    cmd_addr     = '0;
    in_frame_nxt = in_frame_r;
    cnt_nxt      = cnt_r;
    last_len_nxt = last_len_r;
    len_hi_nxt   = len_hi_r;
    len_lo_nxt   = len_lo_r;
    if (sfr_op_t'(in_data.operation) == OP_READ) begin
      cmd.rd_ok = (in_data.read_index < last_len_r) && (32'(rd_pos) < BUF_DEPTH);
      cmd_addr  = AW'(rd_pos);
    end else if (!in_frame_r) begin
      cnt_nxt = '0;
      if (in_data.rx_byte == HEAD_BYTE) begin
        cmd.wr       = 1'b1;
        cmd.data     = in_data.rx_byte;
        in_frame_nxt = 1'b1;
        cnt_nxt      = CW'(1);
      end else begin
        cmd.status = ST_NO_HEAD;
      end
    end else if (cnt_r == CW'(BUF_DEPTH)) begin
      cmd.status   = ST_OVERFLOW;
      in_frame_nxt = 1'b0;
      cnt_nxt      = '0;
    end else begin
      cmd.wr   = 1'b1;
      cmd.data = in_data.rx_byte;
      cmd_addr = cnt_r[AW-1:0];
      cnt_nxt  = cnt_inc;
      if (cnt_r == CW'(1)) len_hi_nxt = in_data.rx_byte;
      if (cnt_r == CW'(2)) len_lo_nxt = in_data.rx_byte;
      if (in_data.rx_byte == TAIL_BYTE && cnt_r > CW'(3)) begin
        in_frame_nxt = 1'b0;
        cnt_nxt      = '0;
        if (match) begin
          cmd.status   = ST_OK;
          last_len_nxt = (field > 16'd255) ? 8'd255 : field[7:0];
        end else begin
          cmd.status   = ST_MISMATCH;
          last_len_nxt = '0;
        end
      end
    end
    cmd.length = last_len_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r      <= 1'b0;
      in_frame_r <= 1'b0;
      cnt_r      <= '0;
      last_len_r <= '0;
    end else begin
      if (cfg_valid) crc_r <= cfg_data;
      if (accept) begin
        in_frame_r <= in_frame_nxt;
        cnt_r      <= cnt_nxt;
        last_len_r <= last_len_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      len_hi_r <= len_hi_nxt;
      len_lo_r <= len_lo_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(BUF_DEPTH))
    else $error("byte count beyond buffer depth");
  a_idle_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    !in_frame_r |-> cnt_r == '0)
    else $error("byte count nonzero outside a frame");
  a_close: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (cmd.status == ST_OK || cmd.status == ST_MISMATCH) |=> !in_frame_r)
    else $error("frame still open after close");

endmodule

// ===== src/sfr_queue.sv =====
// ----------------------------------------------------------------------------
// sfr_queue
// Two-entry command queue between front and back parts.
// ----------------------------------------------------------------------------
module sfr_queue #(
  parameter int AW = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  sfr_pkg::sfr_cmd_t push_cmd,
  input  logic [AW-1:0]     push_addr,
  output logic              not_full,
  input  logic              pop,
  output logic              not_empty,
  output sfr_pkg::sfr_cmd_t pop_cmd,
  output logic [AW-1:0]     pop_addr
);
  import sfr_pkg::*;

  sfr_cmd_t      cmd_r  [2];
  logic [AW-1:0] addr_r [2];
  logic          wptr_r, rptr_r;
  logic [1:0]    cnt_r;

  assign not_full  = (cnt_r != 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign pop_cmd   = cmd_r[rptr_r];
  assign pop_addr  = addr_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (push) wptr_r <= ~wptr_r;
      if (pop)  rptr_r <= ~rptr_r;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      cmd_r[wptr_r]  <= push_cmd;
      addr_r[wptr_r] <= push_addr;
    end
  end

  a_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> not_full)
    else $error("push into full queue");
  a_no_udf: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("pop from empty queue");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("queue count out of range");

endmodule

// ===== src/sfr_back.sv =====
// ----------------------------------------------------------------------------
// sfr_back
// Frame store and output register: carries out queued commands in order.
// ----------------------------------------------------------------------------
module sfr_back #(
  parameter int BUF_DEPTH = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  sfr_pkg::sfr_cmd_t            q_cmd,
  input  logic [$clog2(BUF_DEPTH)-1:0] q_addr,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output sfr_pkg::sfr_out_t            out_data
);
  import sfr_pkg::*;

  logic [7:0] mem [BUF_DEPTH];
  logic       out_valid_r;
  logic [2:0] status_r;
  logic [7:0] length_r;
  logic [7:0] rdata_r;

  assign pop       = q_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = '{status: status_r, payload_length: length_r, read_data: rdata_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Store write and registered read in queue order, one command per cycle unless the output stalls.
  always_ff @(posedge clk) begin
    if (pop) begin
      if (q_cmd.wr) mem[q_addr] <= q_cmd.data;
      rdata_r  <= q_cmd.rd_ok ? mem[q_addr] : 8'd0;
      status_r <= q_cmd.status;
      length_r <= q_cmd.length;
    end
  end

  a_read_status: assert property (@(posedge clk) disable iff (!rst_n)
    pop && q_cmd.rd_ok |=> status_r == ST_NONE)
    else $error("read result carries a frame status");
  a_wr_rd: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !(q_cmd.wr && q_cmd.rd_ok))
    else $error("command both writes and reads");

endmodule

// ===== src/serial_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// serial_frame_receiver
// Head/length/tail framed byte receiver with payload read-back.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request per handshake. operation = OP_RX feeds a received
//           byte, OP_READ reads payload byte read_index of the last good frame.
//   out_* : exactly one result per request, in request order: status,
//           payload_length (last frame length) and read_data.
//   cfg_* : cfg_data sets the check-trailer flag; cfg_ready is always high.
//           Write only while no request is outstanding.
// Path: the front classifies each accepted request into the queue; the back
//   pops it, writes/reads the frame store and registers the result, and
//   out_valid rises with that registered result.
// Throughput: one request per cycle unless out_ready stalls; one store port,
//   used once per request; the two-entry queue keeps streaming at full rate.
// Reset: frame state, length and the trailer flag clear; the frame store
//   is not cleared (reads only reach positions the current frame wrote).
// Stall: when out_ready is low the output holds; the two-entry queue fills,
//   then in_ready drops until the receiver takes a result.
// ----------------------------------------------------------------------------
module serial_frame_receiver #(
  parameter int BUF_DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  sfr_pkg::sfr_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output sfr_pkg::sfr_out_t out_data
);
  import sfr_pkg::*;

  localparam int AW = $clog2(BUF_DEPTH);

  logic          accept;
  sfr_cmd_t      f_cmd, q_cmd;
  logic [AW-1:0] f_addr, q_addr;
  logic          q_not_full, q_not_empty, pop;

  assign cfg_ready = 1'b1;
  assign in_ready  = q_not_full;
  assign accept    = in_valid && in_ready;

  // Front: frame tracking and request classification.
  sfr_front #(.BUF_DEPTH(BUF_DEPTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .in_data   (in_data),
    .cmd       (f_cmd),
    .cmd_addr  (f_addr)
  );

  // Decouples the front from result back-pressure.
  sfr_queue #(.AW(AW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_cmd  (f_cmd),
    .push_addr (f_addr),
    .not_full  (q_not_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .pop_cmd   (q_cmd),
    .pop_addr  (q_addr)
  );

  // Back: frame store access and result register.
  sfr_back #(.BUF_DEPTH(BUF_DEPTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_not_empty),
    .q_cmd     (q_cmd),
    .q_addr    (q_addr),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
